[design/flpmi_pkg.sv]
// ============================================================================
// flpmi_pkg
// Shared types and constants for the four-level page map installer.
// ============================================================================
package flpmi_pkg;

    // Table store geometry
    localparam int FRAME_COUNT     = 512;
    localparam int WORDS_PER_FRAME = 512;
    localparam int IDX_W           = 9;
    localparam int FRAME_W         = $clog2(FRAME_COUNT);
    localparam int MEM_AW          = FRAME_W + IDX_W;
    localparam int STORE_WORDS     = FRAME_COUNT * WORDS_PER_FRAME;

    // Field widths fixed by the interface
    localparam int VA_W       = 48;
    localparam int PA_W       = 52;
    localparam int RADDR_W    = 21;
    localparam int RWORD_W    = RADDR_W - 3;
    localparam int WORD_W     = 64;
    localparam int ROOT_W     = 9;
    localparam int ALLOC_W    = 10;
    localparam int ENTRY_FR_W = WORD_W - 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_LIMIT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [ROOT_W-1:0]  ROOT_RESET        = 9'd0;
    localparam logic [ALLOC_W-1:0] ALLOC_BASE_RESET  = 10'd256;
    localparam logic [ALLOC_W-1:0] ALLOC_LIMIT_RESET = 10'd512;

    // Operation codes
    localparam logic OP_MAP  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Walk levels: three table levels, then the leaf
    localparam logic [1:0] LVL_4    = 2'd0;
    localparam logic [1:0] LVL_3    = 2'd1;
    localparam logic [1:0] LVL_2    = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    // Entry flag bits: present | writable
    localparam logic [11:0] ENTRY_FLAGS = 12'h003;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFRAME = 2'd1,
        STAT_OUTSIDE = 2'd2
    } status_code_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_LEAF,
        ST_READ_RD,
        ST_READ_CHK,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic               operation;
        logic [VA_W-1:0]    virtual_addr;
        logic [PA_W-1:0]    physical_addr;
        logic [RADDR_W-1:0] read_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] read_data;
        logic [1:0]        tables_added;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic         clear_wr;
        logic         load_req;
        logic         walk_rd;
        logic         descend;
        logic         alloc;
        logic         leaf_wr;
        logic         word_rd;
        logic         capture_data;
        logic         set_status;
        status_code_t status_code;
        logic         rsp_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic frame_bad;
        logic present;
        logic alloc_full;
        logic last_level;
        logic word_bad;
        logic rsp_busy;
    } dp_stat_t;

endpackage

[design/flpmi_ctrl.sv]
// ============================================================================
// flpmi_ctrl
// Sequencer for the store clear, the table walk and the word read.
// ============================================================================
module flpmi_ctrl
    import flpmi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = stat.is_read ? ST_READ_RD : ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                state_next = stat.frame_bad ? ST_DONE : ST_WALK_CHK;
            end
            ST_WALK_CHK:
            begin
                if (!stat.present && stat.alloc_full)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = stat.last_level ? ST_LEAF : ST_WALK_RD;
                end
            end
            ST_LEAF:
            begin
                state_next = ST_DONE;
            end
            ST_READ_RD:
            begin
                state_next = stat.word_bad ? ST_DONE : ST_READ_CHK;
            end
            ST_READ_CHK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.rsp_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd             = '0;
        cmd.status_code = STAT_OK;
        req_ready       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_WALK_RD:
            begin
                if (stat.frame_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_OUTSIDE;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                end
            end
            ST_WALK_CHK:
            begin
                if (stat.present)
                begin
                    cmd.descend = 1'b1;
                end
                else if (stat.alloc_full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_NOFRAME;
                end
                else
                begin
                    cmd.alloc = 1'b1;
                end
            end
            ST_LEAF:
            begin
                if (stat.frame_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_OUTSIDE;
                end
                else
                begin
                    cmd.leaf_wr = 1'b1;
                end
            end
            ST_READ_RD:
            begin
                if (stat.word_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_OUTSIDE;
                end
                else
                begin
                    cmd.word_rd = 1'b1;
                end
            end
            ST_READ_CHK:
            begin
                cmd.capture_data = 1'b1;
            end
            ST_DONE:
            begin
                cmd.rsp_load = !stat.rsp_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[design/flpmi_datapath.sv]
// ============================================================================
// flpmi_datapath
// Table store, walk registers, frame allocator, config and result register.
// ============================================================================
module flpmi_datapath
    import flpmi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  req_t                  req,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  rsp_ready,
    output logic                  rsp_valid,
    output rsp_t                  rsp,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat
);

    // Table store
    logic [WORD_W-1:0] store_mem [STORE_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    // Request and walk registers
    req_t                req_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [FRAME_W-1:0]  frame_next;
    logic                frame_bad_reg;
    logic                frame_bad_next;
    logic [1:0]          level_reg;
    logic [1:0]          level_next;
    logic [1:0]          added_reg;
    logic [1:0]          added_next;
    status_code_t        status_reg;
    status_code_t        status_next;
    logic [WORD_W-1:0]   data_reg;

    // Allocator, config, clear sweep and result
    logic [ALLOC_W-1:0]  next_frame_reg;
    logic [ALLOC_W-1:0]  next_frame_next;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W-1:0]   root_next;
    logic [ALLOC_W-1:0]  base_reg;
    logic [ALLOC_W-1:0]  base_next;
    logic [ALLOC_W-1:0]  limit_reg;
    logic [ALLOC_W-1:0]  limit_next;
    logic [MEM_AW-1:0]   clr_cnt_reg;
    logic [MEM_AW-1:0]   clr_cnt_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_t                rsp_reg;

    // Derived values
    logic [IDX_W-1:0]      va_idx;
    logic [MEM_AW-1:0]     walk_addr;
    logic [RWORD_W-1:0]    rd_word;
    logic [ENTRY_FR_W-1:0] entry_frame;
    logic [WORD_W-1:0]     alloc_entry;
    logic [WORD_W-1:0]     leaf_entry;
    logic                  mem_we;
    logic                  mem_re;
    logic [MEM_AW-1:0]     mem_waddr;
    logic [MEM_AW-1:0]     mem_raddr;
    logic [WORD_W-1:0]     mem_wdata;

    // Index slice for the current level
    always_comb
    begin
        case (level_reg)
            LVL_4:    va_idx = req_reg.virtual_addr[47:39];
            LVL_3:    va_idx = req_reg.virtual_addr[38:30];
            LVL_2:    va_idx = req_reg.virtual_addr[29:21];
            LVL_LEAF: va_idx = req_reg.virtual_addr[20:12];
            default:  va_idx = req_reg.virtual_addr[20:12];
        endcase
    end

    assign walk_addr   = {frame_reg, va_idx};
    assign rd_word     = req_reg.read_addr[RADDR_W-1:3];
    assign entry_frame = rdata_reg[WORD_W-1:12];
    assign alloc_entry = {{(WORD_W-ALLOC_W-12){1'b0}}, next_frame_reg, ENTRY_FLAGS};
    assign leaf_entry  = {{(WORD_W-PA_W){1'b0}}, req_reg.physical_addr[PA_W-1:12], ENTRY_FLAGS};

    // Store port selection
    assign mem_we    = cmd.clear_wr | cmd.alloc | cmd.leaf_wr;
    assign mem_re    = cmd.walk_rd | cmd.word_rd;
    assign mem_waddr = cmd.clear_wr ? clr_cnt_reg : walk_addr;
    assign mem_raddr = cmd.word_rd ? MEM_AW'(rd_word) : walk_addr;

    always_comb
    begin
        if (cmd.clear_wr)
        begin
            mem_wdata = '0;
        end
        else if (cmd.alloc)
        begin
            mem_wdata = alloc_entry;
        end
        else
        begin
            mem_wdata = leaf_entry;
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_raddr];
        end
    end

    // Walk state next values
    always_comb
    begin
        frame_next     = frame_reg;
        frame_bad_next = frame_bad_reg;
        level_next     = level_reg;
        added_next     = added_reg;
        status_next    = status_reg;
        if (cmd.load_req)
        begin
            frame_next     = FRAME_W'(root_reg);
            frame_bad_next = 32'(root_reg) >= FRAME_COUNT;
            level_next     = LVL_4;
            added_next     = 2'd0;
            status_next    = STAT_OK;
        end
        if (cmd.descend)
        begin
            frame_next     = FRAME_W'(entry_frame);
            frame_bad_next = entry_frame >= ENTRY_FR_W'(FRAME_COUNT);
            level_next     = level_reg + 2'd1;
        end
        if (cmd.alloc)
        begin
            frame_next     = FRAME_W'(next_frame_reg);
            frame_bad_next = 32'(next_frame_reg) >= FRAME_COUNT;
            level_next     = level_reg + 2'd1;
            added_next     = added_reg + 2'd1;
        end
        if (cmd.set_status)
        begin
            status_next = cmd.status_code;
        end
    end

    // Config and allocator next values
    always_comb
    begin
        root_next       = root_reg;
        base_next       = base_reg;
        limit_next      = limit_reg;
        next_frame_next = next_frame_reg;
        if (cmd.alloc)
        begin
            next_frame_next = next_frame_reg + 10'd1;
        end
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROOT_FRAME:
                begin
                    root_next = cfg_data[ROOT_W-1:0];
                end
                CFG_ALLOC_BASE:
                begin
                    base_next       = cfg_data;
                    next_frame_next = cfg_data;
                end
                CFG_ALLOC_LIMIT:
                begin
                    limit_next = cfg_data;
                end
                default:
                begin
                    root_next = root_reg;
                end
            endcase
        end
    end

    assign clr_cnt_next   = cmd.clear_wr ? clr_cnt_reg + MEM_AW'(1) : clr_cnt_reg;
    assign rsp_valid_next = cmd.rsp_load | (rsp_valid_reg & ~rsp_ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bad_reg  <= 1'b0;
            level_reg      <= LVL_4;
            added_reg      <= 2'd0;
            status_reg     <= STAT_OK;
            next_frame_reg <= ALLOC_BASE_RESET;
            root_reg       <= ROOT_RESET;
            base_reg       <= ALLOC_BASE_RESET;
            limit_reg      <= ALLOC_LIMIT_RESET;
            clr_cnt_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            frame_bad_reg  <= frame_bad_next;
            level_reg      <= level_next;
            added_reg      <= added_next;
            status_reg     <= status_next;
            next_frame_reg <= next_frame_next;
            root_reg       <= root_next;
            base_reg       <= base_next;
            limit_reg      <= limit_next;
            clr_cnt_reg    <= clr_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        if (cmd.load_req)
        begin
            req_reg  <= req;
            data_reg <= '0;
        end
        else if (cmd.capture_data)
        begin
            data_reg <= rdata_reg;
        end
        if (cmd.rsp_load)
        begin
            rsp_reg.status       <= status_reg;
            rsp_reg.read_data    <= data_reg;
            rsp_reg.tables_added <= added_reg;
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.clear_last = clr_cnt_reg == MEM_AW'(STORE_WORDS - 1);
        stat.is_read    = req.operation == OP_READ;
        stat.frame_bad  = frame_bad_reg;
        stat.present    = rdata_reg[0];
        stat.alloc_full = next_frame_reg >= limit_reg;
        stat.last_level = level_reg == LVL_2;
        stat.word_bad   = 32'(rd_word) >= STORE_WORDS;
        stat.rsp_busy   = rsp_valid_reg & ~rsp_ready;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[design/four_level_page_map_installer_unit.sv]
// ============================================================================
// four_level_page_map_installer_unit
// Installs 4 KiB mappings into four-level page tables in a local store.
// ============================================================================
// After reset the block sweeps the table store to zero, one 64-bit word per
// cycle, over FRAME_COUNT*512 words (262144 at the default size); requests
// are held off during the sweep, config writes are taken at any time. A map
// request walks levels 4, 3 and 2, each level taking a store read state and a
// check state (a missing table is allocated and its entry written in the
// check state), then writes the leaf. The walk stops early with an error
// status when a frame lies outside the store or no frame is left to hand
// out. A word read reads the store, then captures the word for the result.
// One request is in flight at a time. Results are held in an output register,
// so a new request is accepted while the previous result waits. Config writes
// are meant to be issued only while the block is idle; writing the allocator
// base also reloads the next frame to hand out.
module four_level_page_map_installer_unit
    import flpmi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer
    flpmi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Store and walk datapath
    flpmi_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef SYNTH
    // One request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while a walk is in flight");

    // Failed requests never return store data
    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STAT_OUTSIDE || rsp.status == STAT_NOFRAME))
        |-> (rsp.read_data == '0))
        else $error("error result carries read data");

    // Allocation only while frames remain
    a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> (!stat.alloc_full && !stat.present))
        else $error("frame allocated past limit or over a present entry");

    // The store sweep holds off requests
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !req_ready)
        else $error("request accepted during store clear");
`endif

endmodule
